FILE: rtl/utfs_pkg.sv
`timescale 1ns / 1ps

package utfs_pkg;

  // Byte queue geometry. The queue_count field is five bits wide, enough to count up to the depth.
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = 5;
  localparam logic [CountW-1:0] QueueFull = CountW'(QueueDepth);

  // Serial frame: start bit, eight data bits, two stop bits.
  localparam int unsigned FrameW   = 11;
  localparam logic [1:0]  StopBits = 2'h3;

  // Operation codes as they arrive on tuser.
  localparam logic [1:0] OpPut   = 2'd0;
  localparam logic [1:0] OpTick  = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;

  typedef enum logic [1:0] {
    CmdPut   = 2'd0,
    CmdTick  = 2'd1,
    CmdFlush = 2'd2,
    CmdNone  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

endpackage

FILE: rtl/utfs_front.sv
`timescale 1ns / 1ps

module utfs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  input  logic [7:0]          in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output utfs_pkg::cmd_t      cmd_o
);

  utfs_pkg::cmd_t cmd_in;
  utfs_pkg::cmd_t slot_q [2];
  logic           wr_idx_q, wr_idx_d;
  logic           rd_idx_q, rd_idx_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  always_comb begin
    cmd_in.data = in_data_i;
    case (in_op_i)
      utfs_pkg::OpPut:   cmd_in.kind = utfs_pkg::CmdPut;
      utfs_pkg::OpTick:  cmd_in.kind = utfs_pkg::CmdTick;
      utfs_pkg::OpFlush: cmd_in.kind = utfs_pkg::CmdFlush;
      default:           cmd_in.kind = utfs_pkg::CmdNone;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_idx_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_idx_d = push ? ~wr_idx_q : wr_idx_q;
    rd_idx_d = pop ? ~rd_idx_q : rd_idx_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_idx_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/utfs_engine.sv
`timescale 1ns / 1ps

module utfs_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  utfs_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_data_o
);

  logic [7:0]                    store_q [utfs_pkg::QueueDepth];
  logic [utfs_pkg::PtrW-1:0]     rd_q, rd_d;
  logic [utfs_pkg::PtrW-1:0]     wr_q, wr_d;
  logic [utfs_pkg::CountW-1:0]   fill_q, fill_d;
  logic [utfs_pkg::FrameW-1:0]   frame_q, frame_d;
  logic                          line_q, line_d;
  logic                          run_q, run_d;
  logic                          out_valid_q;
  logic [7:0]                    out_data_q, out_data_d;
  logic                          fire, wr_en, load, dropped;
  logic [7:0]                    head_byte;
  logic [7:0]                    head_q;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    rd_d      = rd_q;
    wr_d      = wr_q;
    fill_d    = fill_q;
    frame_d   = frame_q;
    line_d    = line_q;
    run_d     = run_q;
    wr_en     = 1'b0;
    load      = 1'b0;
    dropped   = 1'b0;
    head_byte = head_q;

    case (cmd_i.kind)
      utfs_pkg::CmdPut: begin
        if (fill_q < utfs_pkg::QueueFull) begin
          wr_en  = 1'b1;
          wr_d   = utfs_pkg::ptr_inc(wr_q);
          fill_d = fill_q + utfs_pkg::CountW'(1);
        end else begin
          dropped = 1'b1;
        end
        if (frame_q == '0 && fill_d != '0) begin
          load = 1'b1;
          // An empty queue means the head is the byte arriving right now.
          if (fill_q == '0) begin
            head_byte = cmd_i.data;
          end
        end
      end
      utfs_pkg::CmdTick: begin
        if (run_q) begin
          if (frame_q != '0) begin
            line_d  = frame_q[0];
            frame_d = frame_q >> 1;
          end else if (fill_q != '0) begin
            line_d = 1'b1;
            load   = 1'b1;
          end else begin
            run_d = 1'b0;
          end
        end
      end
      utfs_pkg::CmdFlush: begin
        rd_d   = wr_q;
        fill_d = '0;
      end
      default: begin
      end
    endcase

    if (load) begin
      rd_d    = utfs_pkg::ptr_inc(rd_q);
      fill_d  = fill_d - utfs_pkg::CountW'(1);
      frame_d = {utfs_pkg::StopBits, head_byte, 1'b0};
      run_d   = 1'b1;
    end

    out_data_d = {dropped, fill_d, run_d, line_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      fill_q      <= '0;
      frame_q     <= '0;
      line_q      <= 1'b1;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        rd_q    <= rd_d;
        wr_q    <= wr_d;
        fill_q  <= fill_d;
        frame_q <= frame_d;
        line_q  <= line_d;
        run_q   <= run_d;
      end
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
      if (wr_en) begin
        store_q[wr_q] <= cmd_i.data;
      end
      // The byte at the next read pointer is kept registered; a write into that
      // very slot in the same cycle is forwarded.
      if (wr_en && wr_q == rd_d) begin
        head_q <= cmd_i.data;
      end else begin
        head_q <= store_q[rd_d];
      end
    end
  end

endmodule

FILE: rtl/uart_tx_fifo_serializer_unit.sv
`timescale 1ns / 1ps

// Serial transmitter (8 data bits, two stop bits) fed from a 16-byte queue.
// Input channel: tuser carries the operation (put a byte, bit tick, flush),
// tdata carries the byte for a put. Every input beat yields exactly one output
// beat reporting the line level, the running flag, the number of queued bytes
// and whether a put was dropped on a full queue.
// An input beat passes through the two-entry command queue of the front end,
// then through the transmit engine, whose result sits in an output register.
// Throughput is one beat per cycle while the receiver keeps tready high; the
// engine updates all its state at once for each command it takes.
// Reset clears the queue, leaves the line idle high and the transmitter stopped.
// When the receiver holds tready low the output register keeps its beat, the
// engine stops, and the command queue absorbs up to two more beats before
// s_axis_tready_o falls.
module uart_tx_fifo_serializer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [0] line_level, [1] running,
                                        // [6:2] queue_count, [7] dropped
);

  logic           cmd_valid, cmd_ready;
  utfs_pkg::cmd_t cmd;

  utfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  utfs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // The queue never reports more bytes than it holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:2] <= utfs_pkg::QueueFull))
    else $error("queue_count above queue depth");

  // A drop only happens on a full queue, which at most loses one byte to a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[7]) |->
      (m_axis_tdata_o[6:2] >= utfs_pkg::QueueFull - utfs_pkg::CountW'(1)))
    else $error("byte dropped while the queue had room");

  // A stopped transmitter always leaves the line idle high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[1]) |-> m_axis_tdata_o[0])
    else $error("line low while transmitter stopped");

  // A command taken by the engine lands in the output register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> m_axis_tvalid_o)
    else $error("engine result lost");

endmodule
